@@ design/hbc_pkg.sv @@
package hbc_pkg;

  // cache geometry, both powers of two
  localparam int SLOTS         = 1024;
  localparam int INDEX_ENTRIES = 8192;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int IDX_W      = $clog2(INDEX_ENTRIES);
  localparam int FILL_W     = SLOT_W + 1;
  localparam int WORD_W     = 32;
  localparam int OUT_SLOT_W = 10;

  // stream packing
  localparam int IN_TDATA_W  = 2 * WORD_W;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_FIELD_W = 2 * WORD_W + OUT_SLOT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_TUSER_W = 2;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED_C = 2'd3;

  localparam logic [WORD_W-1:0] RNG_SEED_A_RST = 32'd2;
  localparam logic [WORD_W-1:0] RNG_SEED_B_RST = 32'd8;
  localparam logic [WORD_W-1:0] RNG_SEED_C_RST = 32'd16;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // index table port request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [SLOT_W-1:0] data;
  } idx_req_t;

  // slot store port request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] handle;
  } slot_req_t;

endpackage

@@ design/hbc_rng.sv @@
module hbc_rng import hbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 step,
  output logic [WORD_W-1:0]    rnd
);

  logic [WORD_W-1:0] a, b, c;
  logic [WORD_W-1:0] a_next, b_next, c_next;

  // taus88 components
  always_comb begin
    a_next = ({a[WORD_W-1:1], 1'b0} << 12) ^ (((a << 13) ^ a) >> 19);
    b_next = ({b[WORD_W-1:3], 3'b0} << 4) ^ (((b << 2) ^ b) >> 25);
    c_next = ({c[WORD_W-1:4], 4'b0} << 17) ^ (((c << 3) ^ c) >> 11);
    rnd    = a_next ^ b_next ^ c_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= RNG_SEED_A_RST;
      b <= RNG_SEED_B_RST;
      c <= RNG_SEED_C_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RNG_SEED_A: a <= cfg_data;
        REG_RNG_SEED_B: b <= cfg_data;
        REG_RNG_SEED_C: c <= cfg_data;
        default: ;
      endcase
    end else if (step) begin
      a <= a_next;
      b <= b_next;
      c <= c_next;
    end
  end

endmodule

@@ design/hbc_index.sv @@
module hbc_index import hbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  idx_req_t          req,
  output logic [SLOT_W-1:0] rd_data,
  output logic              clearing
);

  logic [SLOT_W-1:0] mem [INDEX_ENTRIES];
  logic [IDX_W-1:0]  clr_addr;

  // zeroing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(INDEX_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.data;
      end else begin
        rd_data <= mem[req.addr];
      end
    end
  end

endmodule

@@ design/hbc_slots.sv @@
module hbc_slots import hbc_pkg::*; (
  input  logic              clk,
  input  slot_req_t         req,
  input  logic [WORD_W-1:0] cmp_id,
  output logic              id_match,
  output logic [WORD_W-1:0] rd_handle
);

  logic [WORD_W-1:0] id_mem     [SLOTS];
  logic [WORD_W-1:0] handle_mem [SLOTS];
  logic [WORD_W-1:0] rd_id;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        id_mem[req.addr]     <= req.id;
        handle_mem[req.addr] <= req.handle;
      end else begin
        rd_id     <= id_mem[req.addr];
        rd_handle <= handle_mem[req.addr];
      end
    end
  end

  assign id_match = (rd_id == cmp_id);

endmodule

@@ design/hashed_block_cache_random_replace.sv @@
// Block handle cache keyed by block id. An index table of 8192 entries maps
// (hash_seed + block_id) to one of 1024 slots; each slot holds a block id and
// its handle. Inserts fill slots 0, 1, 2 ... in order; once all are used an
// insert overwrites a victim slot picked as (hash_seed + r) mod 1024, r from a
// taus88 generator that steps once per such insert, and reports the handle it
// evicted. A lookup reads the index entry, then that slot, and hits only if the
// slot was filled and holds the same id. One beat in, one beat out; items are
// worked one at a time. A lookup goes through index table read, slot store
// read and id compare; an insert writes its slot directly while slots are still
// free, and once full reads the victim, then writes back, since both memories
// read through a register. After reset the index table is zeroed by a sweep
// over all 8192 entries, during which s_tready stays low; configuration writes
// are taken throughout. Writing an rng seed register reloads that generator
// component at once. A spare result register behind the output register lets
// the next beat in while one result waits; s_tready drops once both hold one.
module hashed_block_cache_random_replace import hbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // block_id, block_handle
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // func
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // found_handle, slot_used, evicted_handle, zero pad
  output logic [OUT_TUSER_W-1:0] m_tuser,   // hit, evicted_valid
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for a beat
  localparam logic [1:0] ST_LK_IDX = 2'd1;  // index entry returned, read slot
  localparam logic [1:0] ST_LK_CMP = 2'd2;  // slot returned, compare id
  localparam logic [1:0] ST_EVICT  = 2'd3;  // victim returned, write back

  logic [1:0]        state, state_next;
  logic [WORD_W-1:0] hash_seed;
  logic [FILL_W-1:0] fill_count;

  // item in flight
  logic [WORD_W-1:0] cur_id;
  logic [WORD_W-1:0] cur_handle;
  logic [IDX_W-1:0]  cur_h;
  logic [SLOT_W-1:0] cur_slot;

  // result register
  logic                  out_hit;
  logic [WORD_W-1:0]     out_found;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic                  out_ev_valid;
  logic [WORD_W-1:0]     out_ev_handle;

  // spare result register, holds a result while the output one is stalled
  logic                  spare_valid;
  logic                  spare_hit;
  logic [WORD_W-1:0]     spare_found;
  logic [OUT_SLOT_W-1:0] spare_slot;
  logic                  spare_ev_valid;
  logic [WORD_W-1:0]     spare_ev_handle;

  // result finishing this cycle
  logic                  res_load;
  logic                  res_hit;
  logic [WORD_W-1:0]     res_found;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic                  res_ev_valid;
  logic [WORD_W-1:0]     res_ev_handle;

  // input fields
  logic              in_func;
  logic [WORD_W-1:0] in_id;
  logic [WORD_W-1:0] in_handle;
  logic [IDX_W-1:0]  in_h;

  logic              full;
  logic              out_pop;
  logic              accept;
  logic              ins_fill;
  logic              ins_evict;
  logic              is_lookup;
  logic              rng_step;
  logic [WORD_W-1:0] rnd;
  logic [SLOT_W-1:0] victim;
  logic [SLOT_W-1:0] fill_slot;
  logic              lk_hit;

  idx_req_t          idx_req;
  slot_req_t         slot_req;
  logic [SLOT_W-1:0] idx_rd;
  logic              clearing;
  logic              id_match;
  logic [WORD_W-1:0] slot_handle;

  assign in_func   = s_tuser[0];
  assign in_id     = s_tdata[WORD_W-1:0];
  assign in_handle = s_tdata[2*WORD_W-1:WORD_W];

  // index and victim reductions are plain masks, both sizes are powers of two
  assign in_h      = IDX_W'(hash_seed + in_id);
  assign victim    = SLOT_W'(hash_seed + rnd);
  assign fill_slot = fill_count[SLOT_W-1:0];
  assign full      = (fill_count == FILL_W'(SLOTS));

  // one item in flight at most, so an empty spare always has room for its result
  assign out_pop   = m_tvalid && m_tready;
  assign s_tready  = (state == ST_IDLE) && !clearing && !spare_valid;
  assign accept    = s_tvalid && s_tready;
  assign is_lookup = (in_func == FUNC_LOOKUP);
  assign ins_fill  = accept && !is_lookup && !full;
  assign ins_evict = accept && !is_lookup && full;
  assign rng_step  = ins_evict;

  // a slot never filled is a miss, a stale entry fails the id compare
  assign lk_hit = ({1'b0, cur_slot} < fill_count) && id_match;

  hbc_rng u_rng (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (rng_step),
    .rnd       (rnd)
  );

  hbc_index u_index (
    .clk      (clk),
    .rst      (rst),
    .req      (idx_req),
    .rd_data  (idx_rd),
    .clearing (clearing)
  );

  hbc_slots u_slots (
    .clk       (clk),
    .req       (slot_req),
    .cmp_id    (cur_id),
    .id_match  (id_match),
    .rd_handle (slot_handle)
  );

  // memory port steering
  always_comb begin
    idx_req  = '0;
    slot_req = '0;
    if (accept) begin
      // lookup reads the index entry, a filling insert writes it
      idx_req.en   = is_lookup || !full;
      idx_req.we   = !is_lookup;
      idx_req.addr = in_h;
      idx_req.data = fill_slot;
      // filling insert writes its slot, an evicting insert reads the victim
      slot_req.en     = !is_lookup;
      slot_req.we     = !full;
      slot_req.addr   = full ? victim : fill_slot;
      slot_req.id     = in_id;
      slot_req.handle = in_handle;
    end else if (state == ST_LK_IDX) begin
      slot_req.en   = 1'b1;
      slot_req.addr = idx_rd;
    end else if (state == ST_EVICT) begin
      idx_req.en      = 1'b1;
      idx_req.we      = 1'b1;
      idx_req.addr    = cur_h;
      idx_req.data    = cur_slot;
      slot_req.en     = 1'b1;
      slot_req.we     = 1'b1;
      slot_req.addr   = cur_slot;
      slot_req.id     = cur_id;
      slot_req.handle = cur_handle;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_lookup) begin
          state_next = ST_LK_IDX;
        end else if (ins_evict) begin
          state_next = ST_EVICT;
        end
      end
      ST_LK_IDX: state_next = ST_LK_CMP;
      ST_LK_CMP: state_next = ST_IDLE;
      ST_EVICT:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // result fields of the item that completes this cycle
  always_comb begin
    res_load      = 1'b0;
    res_hit       = 1'b0;
    res_found     = '0;
    res_slot      = '0;
    res_ev_valid  = 1'b0;
    res_ev_handle = '0;
    if (ins_fill) begin
      res_load = 1'b1;
      res_slot = OUT_SLOT_W'(fill_slot);
    end else if (state == ST_LK_CMP) begin
      res_load  = 1'b1;
      res_hit   = lk_hit;
      res_found = lk_hit ? slot_handle : '0;
      res_slot  = OUT_SLOT_W'(cur_slot);
    end else if (state == ST_EVICT) begin
      res_load      = 1'b1;
      res_slot      = OUT_SLOT_W'(cur_slot);
      res_ev_valid  = 1'b1;
      res_ev_handle = slot_handle;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      hash_seed   <= '0;
      m_tvalid    <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_fill) begin
        fill_count <= fill_count + 1'b1;
      end
      if (cfg_we && cfg_index == REG_HASH_SEED) begin
        hash_seed <= cfg_data;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (out_pop) begin
        m_tvalid <= spare_valid;
      end
      // a new result parks in the spare only behind a stalled output beat
      if (res_load && m_tvalid && !out_pop) begin
        spare_valid <= 1'b1;
      end else if (out_pop) begin
        spare_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id     <= in_id;
      cur_handle <= in_handle;
      cur_h      <= in_h;
      cur_slot   <= victim;
    end else if (state == ST_LK_IDX) begin
      cur_slot <= idx_rd;
    end

    if (res_load && (!m_tvalid || out_pop)) begin
      out_hit       <= res_hit;
      out_found     <= res_found;
      out_slot      <= res_slot;
      out_ev_valid  <= res_ev_valid;
      out_ev_handle <= res_ev_handle;
    end else if (out_pop) begin
      out_hit       <= spare_hit;
      out_found     <= spare_found;
      out_slot      <= spare_slot;
      out_ev_valid  <= spare_ev_valid;
      out_ev_handle <= spare_ev_handle;
    end

    if (res_load) begin
      spare_hit       <= res_hit;
      spare_found     <= res_found;
      spare_slot      <= res_slot;
      spare_ev_valid  <= res_ev_valid;
      spare_ev_handle <= res_ev_handle;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_ev_handle, out_slot, out_found};
  assign m_tuser = {out_ev_valid, out_hit};

endmodule

@@ design/hbc_checker.sv @@
module hbc_checker import hbc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  // index sweep keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open right after reset");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a beat never shows both a lookup hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and eviction in one beat");

  // found handle is zero unless hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[WORD_W-1:0] == '0)
    else $error("nonzero handle on a miss");

  // evicted handle is zero unless an eviction
  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[OUT_FIELD_W-1:WORD_W+OUT_SLOT_W] == '0)
    else $error("nonzero evicted handle without eviction");

endmodule

bind hashed_block_cache_random_replace hbc_checker u_hbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hbc_pkg::*;

  // generous cycle budget: index clear plus every item at worst-case stall
  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int ID_POOL      = 64;

  // one result beat, its fields as the checker compares them
  typedef struct packed {
    logic                  hit;
    logic [WORD_W-1:0]     found_handle;
    logic [OUT_SLOT_W-1:0] slot_used;
    logic                  evicted_valid;
    logic [WORD_W-1:0]     evicted_handle;
  } cache_result_t;

  // directed row: typed rows carry a hand-written result, the rest use the predictor
  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] block_id;
    logic [WORD_W-1:0] block_handle;
    logic              typed;
    cache_result_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // block_id, block_handle
  logic [IN_TUSER_W-1:0]  s_tuser;   // func
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // found_handle, slot_used, evicted_handle, zero pad
  logic [OUT_TUSER_W-1:0] m_tuser;   // hit, evicted_valid
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  hashed_block_cache_random_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cache predictor state
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] slot_ids     [SLOTS];
  logic [WORD_W-1:0] slot_handles [SLOTS];
  logic [SLOT_W-1:0] index_map    [INDEX_ENTRIES];
  int                slots_filled;
  logic [WORD_W-1:0] seed_offset;
  logic [WORD_W-1:0] taus_a, taus_b, taus_c;

  cache_result_t     pending_results[$];
  logic [WORD_W-1:0] recent_ids[$];
  int                results_seen = 0;
  int                mismatches   = 0;
  int                cycles       = 0;

  // taus88 step, advances the three components and returns the combined word
  function automatic logic [WORD_W-1:0] taus88_next();
    taus_a = ((taus_a & 32'hFFFF_FFFE) << 12) ^ (((taus_a << 13) ^ taus_a) >> 19);
    taus_b = ((taus_b & 32'hFFFF_FFF8) << 4) ^ (((taus_b << 2) ^ taus_b) >> 25);
    taus_c = ((taus_c & 32'hFFFF_FFF0) << 17) ^ (((taus_c << 3) ^ taus_c) >> 11);
    return taus_a ^ taus_b ^ taus_c;
  endfunction

  // expected result of one accepted request; updates the cache image
  function automatic cache_result_t cache_predict(input logic func,
                                                  input logic [WORD_W-1:0] id,
                                                  input logic [WORD_W-1:0] handle);
    cache_result_t     res;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] victim;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    res = '0;
    sum = seed_offset + id;
    idx = sum[IDX_W-1:0];
    if (func == FUNC_INSERT) begin
      if (slots_filled < SLOTS) begin
        // free slots are handed out in order
        slot = slots_filled[SLOT_W-1:0];
        slots_filled++;
      end else begin
        // full: random victim offset by the hash seed
        victim = seed_offset + taus88_next();
        slot = victim[SLOT_W-1:0];
        res.evicted_valid  = 1'b1;
        res.evicted_handle = slot_handles[slot];
      end
      slot_ids[slot]     = id;
      slot_handles[slot] = handle;
      index_map[idx]     = slot;
    end else begin
      slot = index_map[idx];
      // never-filled slot or a different id (stale entry) is a miss
      if (int'(slot) < slots_filled && slot_ids[slot] == id) begin
        res.hit          = 1'b1;
        res.found_handle = slot_handles[slot];
      end
    end
    res.slot_used = slot;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker, samples at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0d ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0d ns: result beat with nothing expected, expected none, got %h",
                 $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, m_tuser[0]);
        check_field("found_handle", want.found_handle, m_tdata[WORD_W-1:0]);
        check_field("slot_used", want.slot_used, m_tdata[WORD_W +: OUT_SLOT_W]);
        check_field("evicted_valid", want.evicted_valid, m_tuser[1]);
        check_field("evicted_handle", want.evicted_handle,
                    m_tdata[WORD_W+OUT_SLOT_W +: WORD_W]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stalls on its own pattern, with long hold-offs to back up the block
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int tick;
    int hold_at;
    m_tready  = 1'b0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    hold_at   = 120;
    forever begin
      if (results_seen >= hold_at) begin
        // long hold while the sender keeps pushing, input side must stall
        hold_at += 1200;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 3 != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // directed rows, hash seed 0 and an empty cache
  dir_row_t dir_rows [16] = '{
    // empty cache: index 0 names slot 0, which was never filled
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 10'd0, 1'b0, 32'h0}},
    '{FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 10'd0, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 10'd0, 1'b0, 32'h0}},
    '{FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 10'd1, 1'b0, 32'h0}},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 10'd1, 1'b0, 32'h0}},
    // same index as id 0, different id
    '{FUNC_LOOKUP, 32'h0000_2000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 10'd0, 1'b0, 32'h0}},
    '{FUNC_INSERT, 32'h0000_2000, 32'h1234_5678, 1'b1, '{1'b0, 32'h0, 10'd2, 1'b0, 32'h0}},
    // stale entry: index 0 now names slot 2
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 10'd2, 1'b0, 32'h0}},
    // handle on a lookup is ignored
    '{FUNC_LOOKUP, 32'h0000_2000, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 32'h1234_5678, 10'd2, 1'b0, 32'h0}},
    '{FUNC_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{FUNC_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{FUNC_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
    '{FUNC_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
    // re-insert of a cached id takes a fresh slot
    '{FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0}
  };

  // one beat, called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic func, input logic [WORD_W-1:0] id,
                           input logic [WORD_W-1:0] handle, input logic typed,
                           input cache_result_t want);
    cache_result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {handle, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = cache_predict(func, id, handle);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // drop valid, wait for every outstanding result, then idle before returning
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    // seed writes reload the generator component at once
    case (idx)
      REG_HASH_SEED:  seed_offset = value;
      REG_RNG_SEED_A: taus_a = value;
      REG_RNG_SEED_B: taus_b = value;
      REG_RNG_SEED_C: taus_c = value;
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [WORD_W-1:0] hash_seed, input logic [WORD_W-1:0] sa,
                           input logic [WORD_W-1:0] sb, input logic [WORD_W-1:0] sc);
    reg_write(REG_HASH_SEED, hash_seed);
    reg_write(REG_RNG_SEED_A, sa);
    reg_write(REG_RNG_SEED_B, sb);
    reg_write(REG_RNG_SEED_C, sc);
    cfg_we <= 1'b0;
  endtask

  // ids: random, crowded onto 32 index entries, recently inserted ones or one bit off
  function automatic logic [WORD_W-1:0] pick_id(input logic for_lookup);
    logic [WORD_W-1:0] id;
    int                sel;
    id  = $urandom;
    sel = $urandom_range(0, 99);
    if (recent_ids.size() != 0) begin
      if (for_lookup && sel < 60)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      else if (for_lookup && sel < 70)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
      else if (sel >= 85)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      else if (sel >= 70)
        id[IDX_W-1:0] = IDX_W'($urandom_range(0, 31));
    end
    return id;
  endfunction

  function automatic logic [WORD_W-1:0] pick_handle();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random traffic in bursts; pause_at >= 0 stops once until all results are back
  task automatic run_phase(input int n_items, input int insert_pct, input int pause_at);
    int                burst_left;
    int                gap;
    logic              func;
    logic [WORD_W-1:0] id;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      if (burst_left > 0) burst_left--;
      func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_LOOKUP;
      id   = pick_id(func == FUNC_LOOKUP);
      if (func == FUNC_INSERT) begin
        recent_ids.push_back(id);
        if (recent_ids.size() > ID_POOL) void'(recent_ids.pop_front());
      end
      send_item(func, id, pick_handle(), 1'b0, '0);
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    slots_filled = 0;
    seed_offset  = '0;
    taus_a       = RNG_SEED_A_RST;
    taus_b       = RNG_SEED_B_RST;
    taus_c       = RNG_SEED_C_RST;
    foreach (index_map[i]) index_map[i] = '0;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset configuration
    foreach (dir_rows[k])
      send_item(dir_rows[k].func, dir_rows[k].block_id, dir_rows[k].block_handle,
                dir_rows[k].typed, dir_rows[k].want);
    drain_results();

    // partly filled cache, random hash offset
    load_regs($urandom, $urandom, $urandom, $urandom);
    run_phase(300, 50, 150);
    drain_results();

    // fill up and cross into replacement, largest hash offset, reset seeds
    load_regs('1, RNG_SEED_A_RST, RNG_SEED_B_RST, RNG_SEED_C_RST);
    run_phase(SLOTS - slots_filled + 150, 95, -1);
    drain_results();

    // all-ones seeds
    load_regs('0, '1, '1, '1);
    run_phase(150, 50, 75);
    drain_results();

    // zero seeds: generator stuck at zero, every victim is the hash offset
    load_regs(32'd1, '0, '0, '0);
    run_phase(60, 50, -1);
    drain_results();

    // seeds just under their minimums
    load_regs($urandom, 32'd1, 32'd7, 32'd15);
    run_phase(60, 50, -1);
    drain_results();

    // fully random settings
    load_regs($urandom, $urandom, $urandom, $urandom);
    run_phase(150, 60, -1);
    drain_results();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
